/* rtl/core/sine_cosine_taylor_core_defines.svh */
// Assertion macros used by the core's top-level RTL file.
`ifndef SINE_COSINE_TAYLOR_CORE_DEFINES_SVH
`define SINE_COSINE_TAYLOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SCT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/sct_pkg.sv */
package sct_pkg;

   localparam int ANGLE_W   = 32;
   localparam int RED_W     = 31;
   localparam int X2_W      = 34;
   localparam int MAG_W     = 33;
   localparam int F_W       = 33;
   localparam int SUM_W     = 36;
   localparam int RECIP_W   = 30;
   localparam int VALUE_W   = 32;
   localparam int STEP_IDX_W = 4;
   localparam int MAX_STEPS = 16;
   localparam int Q30_SHIFT = 30;

   // pi and 2*pi in Q3.28, widened by one bit for the reduction arithmetic
   localparam logic signed [ANGLE_W:0] PI_Q28     = 33'sd843314857;
   localparam logic signed [ANGLE_W:0] TWO_PI_Q28 = 33'sd1686629713;

   localparam logic signed [SUM_W-1:0]   ONE_SUM   = 36'sd1073741824;
   localparam logic [MAG_W-1:0]          ONE_MAG   = 33'd1073741824;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh4000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'shC000_0000;

   typedef enum logic {
      KIND_SINE   = 1'b0,
      KIND_COSINE = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic signed [RED_W-1:0]   angle;
   } sct_red_type;

   typedef struct packed {
      kind_type                  kind;
      logic [X2_W-1:0]           x2;
      logic                      term_neg;
      logic [MAG_W-1:0]          term_mag;
      logic [F_W-1:0]            f;
      logic signed [SUM_W-1:0]   sum;
   } sct_stage_type;

   // round(2^30 / (k*(k+1))), k = 2i for sine; entry 0 unused
   localparam logic [RECIP_W-1:0] RECIP_SIN [0:MAX_STEPS-1] = '{
      30'd0,        30'd178956971, 30'd53687091, 30'd25565282,
      30'd14913081, 30'd9761289,   30'd6882960,  30'd5113056,
      30'd3947580,  30'd3139596,   30'd2556528,  30'd2122019,
      30'd1789570,  30'd1529547,   30'd1322342,  30'd1154561
   };

   // same with k = 2i-1 for cosine
   localparam logic [RECIP_W-1:0] RECIP_COS [0:MAX_STEPS-1] = '{
      30'd0,        30'd536870912, 30'd89478485, 30'd35791394,
      30'd19173961, 30'd11930465,  30'd8134408,  30'd5899680,
      30'd4473924,  30'd3508960,   30'd2825636,  30'd2324117,
      30'd1945184,  30'd1651910,   30'd1420293,  30'd1234186
   };

   function automatic logic [RECIP_W-1:0] sct_recip(kind_type kind,
                                                    logic [STEP_IDX_W-1:0] step);
      return (kind == KIND_COSINE) ? RECIP_COS[step] : RECIP_SIN[step];
   endfunction

   // signed value of a sign-magnitude term
   function automatic logic signed [SUM_W-1:0] sct_term_value(logic neg,
                                                              logic [MAG_W-1:0] mag);
      logic signed [SUM_W-1:0] wide;
      wide = $signed(SUM_W'(mag));
      return neg ? -wide : wide;
   endfunction

endpackage

/* rtl/core/sct_reduce.sv */
module sct_reduce (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                prev_valid,
   input  sct_pkg::kind_type   prev_kind,
   input  logic [31:0]         prev_angle,
   output logic                stage_valid,
   output sct_pkg::sct_red_type stage_data
);
   import sct_pkg::*;

   logic                    valid_ff;
   sct_red_type             data_ff;
   sct_red_type             data_in;
   logic signed [ANGLE_W:0] wide;
   logic signed [ANGLE_W:0] reduced;

   // fold once into [-pi, pi]; exactly +/-pi stays put
   always_comb begin
      wide = $signed({prev_angle[ANGLE_W-1], prev_angle});
      if (wide > PI_Q28) begin
         reduced = wide - TWO_PI_Q28;
      end else if (wide < -PI_Q28) begin
         reduced = wide + TWO_PI_Q28;
      end else begin
         reduced = wide;
      end
      data_in.kind  = prev_kind;
      data_in.angle = reduced[RED_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && prev_valid) begin
         data_ff <= data_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

endmodule

/* rtl/core/sct_square.sv */
module sct_square (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   prev_valid,
   input  sct_pkg::sct_red_type   prev_data,
   output logic                   stage_valid,
   output sct_pkg::sct_stage_type stage_data
);
   import sct_pkg::*;

   logic                       valid_ff;
   sct_stage_type              data_ff;
   sct_stage_type              data_in;
   logic signed [2*RED_W-1:0]  square;
   logic [2*RED_W-1:0]         square_round;
   logic [RED_W-1:0]           angle_abs;

   // (4a)^2 >> 30 rounded is (a^2 + 2^25) >> 26
   assign square       = prev_data.angle * prev_data.angle;
   assign square_round = $unsigned(square) + (2*RED_W)'(1 << 25);
   assign angle_abs    = prev_data.angle[RED_W-1] ? $unsigned(-prev_data.angle)
                                                  : $unsigned(prev_data.angle);

   always_comb begin
      data_in.kind = prev_data.kind;
      data_in.x2   = square_round[26 +: X2_W];
      if (prev_data.kind == KIND_COSINE) begin
         data_in.term_neg = 1'b0;
         data_in.term_mag = ONE_MAG;
      end else begin
         data_in.term_neg = prev_data.angle[RED_W-1];
         data_in.term_mag = MAG_W'({angle_abs, 2'b00});
      end
      data_in.f   = '0;
      data_in.sum = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && prev_valid) begin
         data_ff <= data_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

endmodule

/* rtl/core/sct_term.sv */
module sct_term #(
   parameter int STEP  = 0,
   parameter int TERMS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   prev_valid,
   input  sct_pkg::sct_stage_type prev_data,
   output logic                   stage_valid,
   output sct_pkg::sct_stage_type stage_data
);
   import sct_pkg::*;

   logic          valid_ff;
   sct_stage_type data_ff;
   sct_stage_type data_in;
   logic [F_W-1:0]   f_next;
   logic             term_neg_next;
   logic [MAG_W-1:0] term_mag_next;
   logic signed [SUM_W-1:0] sum_next;

   // factor for the following step: round(x2 * recip >> 30)
   generate
      if (STEP + 1 < TERMS) begin : g_factor
         localparam logic [STEP_IDX_W-1:0] NEXT_STEP = STEP_IDX_W'(STEP + 1);
         logic [RECIP_W-1:0]        recip;
         logic [X2_W+RECIP_W-1:0]   f_prod;
         logic [X2_W+RECIP_W-1:0]   f_round;
         assign recip   = sct_recip(prev_data.kind, NEXT_STEP);
         assign f_prod  = (X2_W+RECIP_W)'(prev_data.x2) * (X2_W+RECIP_W)'(recip);
         assign f_round = f_prod + (X2_W+RECIP_W)'(1 << (Q30_SHIFT - 1));
         assign f_next  = f_round[Q30_SHIFT +: F_W];
      end else begin : g_no_factor
         assign f_next = '0;
      end
   endgenerate

   // term = -(term * f); accumulate the term it replaces
   generate
      if (STEP > 0) begin : g_term
         logic [MAG_W+F_W-1:0] t_prod;
         logic [MAG_W+F_W-1:0] t_round;
         assign t_prod        = (MAG_W+F_W)'(prev_data.term_mag) * (MAG_W+F_W)'(prev_data.f);
         assign t_round       = t_prod + (MAG_W+F_W)'(1 << (Q30_SHIFT - 1));
         assign term_mag_next = t_round[Q30_SHIFT +: MAG_W];
         assign term_neg_next = ~prev_data.term_neg;
         assign sum_next      = prev_data.sum
                                + sct_term_value(prev_data.term_neg, prev_data.term_mag);
      end else begin : g_first
         assign term_mag_next = prev_data.term_mag;
         assign term_neg_next = prev_data.term_neg;
         assign sum_next      = prev_data.sum;
      end
   endgenerate

   always_comb begin
      data_in          = prev_data;
      data_in.f        = f_next;
      data_in.term_neg = term_neg_next;
      data_in.term_mag = term_mag_next;
      data_in.sum      = sum_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && prev_valid) begin
         data_ff <= data_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

endmodule

/* rtl/core/sct_out.sv */
module sct_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   prev_valid,
   input  sct_pkg::sct_stage_type prev_data,
   output logic                   stage_valid,
   output logic [31:0]            stage_value
);
   import sct_pkg::*;

   logic                    valid_ff;
   logic [VALUE_W-1:0]      value_ff;
   logic [VALUE_W-1:0]      value_in;
   logic signed [SUM_W-1:0] total;

   assign total = prev_data.sum + sct_term_value(prev_data.term_neg, prev_data.term_mag);

   // clamp to plus or minus one
   always_comb begin
      if (total > ONE_SUM) begin
         value_in = VALUE_MAX;
      end else if (total < -ONE_SUM) begin
         value_in = VALUE_MIN;
      end else begin
         value_in = total[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && prev_valid) begin
         value_ff <= value_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_value = value_ff;

endmodule

/* rtl/core/sine_cosine_taylor_core.sv */
// Sine or cosine of a Q3.28 angle in radians by a TERMS-term Taylor series,
// result in Q2.30 clamped to plus or minus one. One transfer is taken every
// cycle unless a stall has filled every stage. From input to output register
// an item passes a stage that folds the angle into [-pi, pi], one that
// squares it, one stage per series term (at most one term multiply plus the
// multiply for the next factor), and a last stage that adds the final term
// and clamps. Every stage holds its own valid bit and empty stages fill under
// a stall, so input is still taken while a finished result waits at the output.
`include "sine_cosine_taylor_core_defines.svh"

module sine_cosine_taylor_core #(
   parameter int TERMS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] angle
   input  logic [0:0]  req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] value
);
   import sct_pkg::*;

   localparam int NS = TERMS + 3;

   logic [NS-1:0]  valid;
   logic [NS-1:0]  advance;
   sct_red_type    red_data;
   sct_stage_type  stage_data [0:TERMS];

   // a stage moves on when it is empty or the one after it moves
   assign advance[NS-1] = ~valid[NS-1] | rsp_tready;
   genvar k;
   generate
      for (k = 0; k < NS - 1; k++) begin : g_adv
         assign advance[k] = ~valid[k] | advance[k+1];
      end
   endgenerate

   assign req_tready = advance[0];

   sct_reduce u_reduce (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance[0]),
      .prev_valid  (req_tvalid),
      .prev_kind   (kind_type'(req_tuser[0])),
      .prev_angle  (req_tdata),
      .stage_valid (valid[0]),
      .stage_data  (red_data)
   );

   sct_square u_square (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance[1]),
      .prev_valid  (valid[0]),
      .prev_data   (red_data),
      .stage_valid (valid[1]),
      .stage_data  (stage_data[0])
   );

   generate
      for (k = 0; k < TERMS; k++) begin : g_step
         sct_term #(
            .STEP  (k),
            .TERMS (TERMS)
         ) u_term (
            .clock       (clock),
            .reset       (reset),
            .advance     (advance[k+2]),
            .prev_valid  (valid[k+1]),
            .prev_data   (stage_data[k]),
            .stage_valid (valid[k+2]),
            .stage_data  (stage_data[k+1])
         );
      end
   endgenerate

   sct_out u_out (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance[NS-1]),
      .prev_valid  (valid[NS-2]),
      .prev_data   (stage_data[TERMS]),
      .stage_valid (valid[NS-1]),
      .stage_value (rsp_tdata)
   );

   assign rsp_tvalid = valid[NS-1];

   `SCT_ASSERT_NOW(a_value_clamped, clock, reset, rsp_tvalid, ($signed(rsp_tdata) <= VALUE_MAX) && ($signed(rsp_tdata) >= VALUE_MIN), "result beyond plus or minus one")
   `SCT_ASSERT_NOW(a_angle_folded, clock, reset, valid[0], (red_data.angle <= PI_Q28) && (red_data.angle >= -PI_Q28), "folded angle outside plus or minus pi")
   `SCT_ASSERT_NEXT(a_accept_loads, clock, reset, req_tvalid && req_tready, valid[0], "accepted transfer not held in first stage")

endmodule
